// ===== src/ttcb_pkg.sv =====
// ----------------------------------------------------------------------------
// ttcb_pkg
// Shared types and constants of the time-to-collision brake core.
// ----------------------------------------------------------------------------
`default_nettype none

package ttcb_pkg;

    // Input item: velocity update or lidar range sample
    typedef struct packed {
        logic               req_type;
        logic        [15:0] range_mm;
        logic               range_valid;
        logic               last_beam;
        logic signed [15:0] vel_x_mm_s;
        logic signed [15:0] vel_y_mm_s;
    } t_ttcb_in;

    // Result item: one per scan
    typedef struct packed {
        logic        brake;
        logic [16:0] min_ttc_ms;
    } t_ttcb_out;

    // Configuration register file
    typedef struct packed {
        logic        [16:0] ttc_threshold_ms;
        logic signed [15:0] start_angle;
        logic        [11:0] angle_step;
    } t_ttcb_cfg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TTC_THRESHOLD = 2'd0,
        CFG_START_ANGLE   = 2'd1,
        CFG_ANGLE_STEP    = 2'd2
    } t_cfg_idx;

    localparam logic            REQ_VELOCITY = 1'b0;
    localparam logic            REQ_RANGE    = 1'b1;

    localparam logic     [16:0] TTC_CEIL_MS       = 17'd100000;
    localparam logic     [16:0] THRESHOLD_RST     = 17'd400;
    localparam logic     [15:0] START_ANGLE_RST   = 16'hA000;
    localparam logic     [11:0] ANGLE_STEP_RST    = 12'd45;
    localparam logic     [15:0] QUARTER_TURN      = 16'h4000;
    localparam logic     [16:0] MS_PER_S          = 17'd1000;

    // quotient bits produced by the divider: enough to cover the ceiling
    localparam int unsigned DIV_STEPS = 17;

endpackage : ttcb_pkg

`default_nettype wire

// ===== src/lidar_time_to_collision_brake_core.sv =====
// ----------------------------------------------------------------------------
// lidar_time_to_collision_brake_core
// Time-to-collision emergency brake over a lidar scan: configuration
// registers, input handshake and result register around the beam engine.
// ----------------------------------------------------------------------------
// A velocity update is taken and the core is ready again at once. A range
// sample holds the input stalled while it is worked: a skipped beam goes
// straight to the final state, a beam with a non-positive closing rate or a
// time beyond the ceiling leaves after the check, and a beam that goes
// through the divider runs the 17-step restoring divider and the minimum
// step before the next possible transfer. The multiplier and the sine ROM (one
// registered read per cycle, cos then sin) are shared over the steps before
// the divider. A last beam waits in the engine while a previous scan result
// still sits unread in the output register. The sine ROM holds a quarter
// wave of 2^(TRIG_TABLE_BITS-2)+1 entries.
`default_nettype none

module lidar_time_to_collision_brake_core #(
    parameter int unsigned TRIG_TABLE_BITS = 10
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire ttcb_pkg::t_ttcb_in                    i_in_data,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output ttcb_pkg::t_ttcb_out                        o_out_data,
    input  wire logic                                  i_cfg_we,
    input  wire logic [ttcb_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [ttcb_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    ttcb_pkg::t_ttcb_cfg r_cfg;
    logic                r_out_valid;
    ttcb_pkg::t_ttcb_out r_out_data;

    logic                w_idle;
    logic                w_start;
    logic                w_out_free;
    logic                w_angle_load;
    logic                w_res_valid;
    ttcb_pkg::t_ttcb_out w_res;

    assign o_in_stall   = !w_idle;
    assign w_start      = i_in_valid && w_idle;
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_angle_load = i_cfg_we &&
                          (i_cfg_idx == ttcb_pkg::CFG_START_ANGLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ttc_threshold_ms <= ttcb_pkg::THRESHOLD_RST;
            r_cfg.start_angle      <= ttcb_pkg::START_ANGLE_RST;
            r_cfg.angle_step       <= ttcb_pkg::ANGLE_STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ttcb_pkg::CFG_TTC_THRESHOLD: r_cfg.ttc_threshold_ms <= i_cfg_data;
                ttcb_pkg::CFG_START_ANGLE:   r_cfg.start_angle      <= i_cfg_data[15:0];
                ttcb_pkg::CFG_ANGLE_STEP:    r_cfg.angle_step       <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    ttcb_engine #(
        .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_start),
        .i_item        (i_in_data),
        .i_cfg         (r_cfg),
        .i_angle_load  (w_angle_load),
        .i_angle_value (i_cfg_data[15:0]),
        .i_out_free    (w_out_free),
        .o_idle        (w_idle),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    // result register, refilled in the cycle it is transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out_data <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> !r_out_valid || !i_out_stall)
        else $error("result overwrites an untransferred result");

    a_stall_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_start && i_in_data.req_type == ttcb_pkg::REQ_RANGE) |-> o_in_stall)
        else $error("range sample transferred without going busy");

    a_brake_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> (w_res.brake == (w_res.min_ttc_ms <= r_cfg.ttc_threshold_ms)))
        else $error("brake flag disagrees with threshold");
`endif

endmodule : lidar_time_to_collision_brake_core

`default_nettype wire

// ===== src/ttcb_trig_rom.sv =====
// ----------------------------------------------------------------------------
// ttcb_trig_rom
// Quarter-wave sine ROM, Q1.15, one registered read per cycle. Takes a 16-bit
// binary angle, truncates it to the table resolution and folds the quadrant.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcb_trig_rom #(
    parameter int unsigned TRIG_TABLE_BITS = 10
) (
    input  wire logic               i_clk,
    input  wire logic        [15:0] i_angle,
    output logic signed      [15:0] o_value
);

    localparam int unsigned QTR_BITS  = TRIG_TABLE_BITS - 2;
    localparam int unsigned QTR_DEPTH = (2 ** QTR_BITS) + 1;
    localparam int unsigned ADDR_W    = QTR_BITS + 1;
    localparam int unsigned SHIFT     = 16 - TRIG_TABLE_BITS;

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q16 = 64'd102944;

    localparam logic [ADDR_W-1:0] QTR_FULL = {1'b1, {QTR_BITS{1'b0}}};

    // Odd Taylor series to degree 11 in Q30, truncating shifts
    function automatic logic [15*QTR_DEPTH-1:0] build_rom();
        logic [15*QTR_DEPTH-1:0] rom;
        logic [63:0]             x;
        logic [63:0]             x2;
        logic [63:0]             t;
        logic [63:0]             s;
        int                      k;
        rom = '0;
        for (k = 0; k < QTR_DEPTH; k++) begin
            x  = (64'(k) << SHIFT) * HALF_PI_Q16;
            x2 = (x * x) >> 30;
            t  = Q30_ONE;
            t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
            t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
            t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
            t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
            t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
            s  = (x * t) >> 30;
            s  = (s + 64'd16384) >> 15;
            if (s > 64'd32767) begin
                s = 64'd32767;
            end
            rom[k*15 +: 15] = s[14:0];
        end
        return rom;
    endfunction

    localparam logic [15*QTR_DEPTH-1:0] ROM = build_rom();

    logic [TRIG_TABLE_BITS-1:0] w_idx;
    logic [QTR_BITS-1:0]        w_ofs;
    logic [ADDR_W-1:0]          w_addr;
    logic [14:0]                r_mag;
    logic                       r_neg;

    assign w_idx  = i_angle[15 -: TRIG_TABLE_BITS];
    assign w_ofs  = w_idx[QTR_BITS-1:0];
    // second and fourth quadrants run the table backwards
    assign w_addr = w_idx[QTR_BITS] ? (QTR_FULL - {1'b0, w_ofs}) : {1'b0, w_ofs};

    always_ff @(posedge i_clk) begin
        r_mag <= ROM[w_addr*15 +: 15];
        r_neg <= w_idx[QTR_BITS+1];
    end

    assign o_value = r_neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});

endmodule : ttcb_trig_rom

`default_nettype wire

// ===== src/ttcb_engine.sv =====
// ----------------------------------------------------------------------------
// ttcb_engine
// Beam sequencer: trig lookups, one shared 17x17 multiplier for the closing
// rate and the range numerator, a restoring divider and the scan minimum.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcb_engine #(
    parameter int unsigned TRIG_TABLE_BITS = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire ttcb_pkg::t_ttcb_in i_item,
    input  wire ttcb_pkg::t_ttcb_cfg i_cfg,
    input  wire logic               i_angle_load,
    input  wire logic        [15:0] i_angle_value,
    input  wire logic               i_out_free,
    output logic                    o_idle,
    output logic                    o_res_valid,
    output ttcb_pkg::t_ttcb_out     o_res
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_RD_COS = 10'b00_0000_0010,
        S_RD_SIN = 10'b00_0000_0100,
        S_MUL_X  = 10'b00_0000_1000,
        S_MUL_Y  = 10'b00_0001_0000,
        S_MUL_R  = 10'b00_0010_0000,
        S_CHECK  = 10'b00_0100_0000,
        S_DIV    = 10'b00_1000_0000,
        S_MIN    = 10'b01_0000_0000,
        S_FIN    = 10'b10_0000_0000
    } t_state;

    localparam logic [4:0] DIV_LAST = 5'(ttcb_pkg::DIV_STEPS - 1);

    t_state             r_state;
    t_state             n_state;
    logic        [15:0] r_angle;
    logic        [16:0] r_min;
    logic signed [15:0] r_vel_x;
    logic signed [15:0] r_vel_y;
    logic        [15:0] r_range;
    logic               r_last;
    logic signed [15:0] r_cos;
    logic signed [15:0] r_sin;
    logic signed [33:0] r_prod;
    logic signed [32:0] r_acc;
    logic        [30:0] r_rem;
    logic        [16:0] r_quo;
    logic        [4:0]  r_cnt;

    logic        [15:0] w_rom_angle;
    logic signed [15:0] w_rom_value;
    logic signed [16:0] w_mul_a;
    logic signed [16:0] w_mul_b;
    logic signed [33:0] w_prod;
    logic               w_rate_pos;
    logic        [30:0] w_rate;
    logic        [30:0] w_num_hi;
    logic        [31:0] w_shift;
    logic        [32:0] w_trial;
    logic               w_emit;

    assign w_rom_angle = (r_state == S_RD_COS) ? (r_angle + ttcb_pkg::QUARTER_TURN) : r_angle;

    ttcb_trig_rom #(
        .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
    ) u_trig_rom (
        .i_clk   (i_clk),
        .i_angle (w_rom_angle),
        .o_value (w_rom_value)
    );

    // shared multiplier operand select
    always_comb begin
        unique case (r_state)
            S_MUL_X: begin
                w_mul_a = 17'(r_cos);
                w_mul_b = 17'(r_vel_x);
            end
            S_MUL_Y: begin
                w_mul_a = 17'(r_sin);
                w_mul_b = 17'(r_vel_y);
            end
            S_MUL_R: begin
                w_mul_a = $signed({1'b0, r_range});
                w_mul_b = $signed(ttcb_pkg::MS_PER_S);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // closing rate stays below 2^31
    assign w_rate_pos = !r_acc[32] && (r_acc != '0);
    assign w_rate     = r_acc[30:0];
    // numerator is range*1000*2^15; its part above the 17 quotient bits
    assign w_num_hi   = {7'd0, r_prod[25:2]};
    assign w_shift    = {r_rem, r_quo[16]};
    assign w_trial    = {1'b0, w_shift} - {2'b00, w_rate};

    assign w_emit = (r_state == S_FIN) && r_last && i_out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && (i_item.req_type == ttcb_pkg::REQ_RANGE)) begin
                    n_state = i_item.range_valid ? S_RD_COS : S_FIN;
                end
            end
            S_RD_COS: n_state = S_RD_SIN;
            S_RD_SIN: n_state = S_MUL_X;
            S_MUL_X:  n_state = S_MUL_Y;
            S_MUL_Y:  n_state = S_MUL_R;
            S_MUL_R:  n_state = S_CHECK;
            S_CHECK: begin
                // quotient at or above 2^17 can never beat the minimum
                if (!w_rate_pos || (w_num_hi >= w_rate)) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = S_MIN;
                end
            end
            S_MIN: n_state = S_FIN;
            S_FIN: begin
                if (!r_last || i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_angle <= ttcb_pkg::START_ANGLE_RST;
            r_min   <= ttcb_pkg::TTC_CEIL_MS;
            r_vel_x <= '0;
            r_vel_y <= '0;
        end else begin
            r_state <= n_state;

            if (i_start && (i_item.req_type == ttcb_pkg::REQ_VELOCITY)) begin
                r_vel_x <= i_item.vel_x_mm_s;
                r_vel_y <= i_item.vel_y_mm_s;
            end

            priority if (i_angle_load) begin
                r_angle <= i_angle_value;
            end else if (w_emit) begin
                r_angle <= i_cfg.start_angle;
            end else if ((r_state == S_FIN) && !r_last) begin
                r_angle <= r_angle + {4'd0, i_cfg.angle_step};
            end else begin
                r_angle <= r_angle;
            end

            priority if (w_emit) begin
                r_min <= ttcb_pkg::TTC_CEIL_MS;
            end else if ((r_state == S_MIN) && (r_quo < r_min)) begin
                r_min <= r_quo;
            end else begin
                r_min <= r_min;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_start) begin
            r_range <= i_item.range_mm;
            r_last  <= i_item.last_beam;
        end
        if (r_state == S_RD_SIN) begin
            r_cos <= w_rom_value;
        end
        if (r_state == S_MUL_X) begin
            r_sin <= w_rom_value;
        end
        r_prod <= w_prod;
        if (r_state == S_MUL_Y) begin
            r_acc <= r_prod[32:0];
        end else if (r_state == S_MUL_R) begin
            r_acc <= r_acc + $signed(r_prod[32:0]);
        end
        if (r_state == S_CHECK) begin
            r_rem <= w_num_hi;
            r_quo <= {r_prod[1:0], 15'd0};
            r_cnt <= '0;
        end else if (r_state == S_DIV) begin
            // restoring step: numerator bits shift out as quotient bits shift in
            if (!w_trial[32]) begin
                r_rem <= w_trial[30:0];
            end else begin
                r_rem <= w_shift[30:0];
            end
            r_quo <= {r_quo[15:0], !w_trial[32]};
            r_cnt <= r_cnt + 5'd1;
        end
    end

    assign o_idle            = (r_state == S_IDLE);
    assign o_res_valid       = w_emit;
    assign o_res.brake       = (r_min <= i_cfg.ttc_threshold_ms);
    assign o_res.min_ttc_ms  = r_min;

`ifndef SYNTH
    a_res_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (r_state == S_FIN) && r_last)
        else $error("result outside final state of a last beam");

    a_min_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_min == ttcb_pkg::TTC_CEIL_MS))
        else $error("scan minimum not restarted after result");

    a_min_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_min <= ttcb_pkg::TTC_CEIL_MS)
        else $error("scan minimum above ceiling");

    a_rem_below_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < w_rate))
        else $error("divider remainder not below closing rate");

    a_div_from_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_DIV) |-> $past(r_state == S_CHECK) && (r_cnt == 5'd0))
        else $error("divider entered without setup");
`endif

endmodule : ttcb_engine

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the lidar time-to-collision brake core. A table of
// directed rows runs first, then random scans over several register settings.
// Every result is checked against a bit-exact scan predictor or the typed
// row result, with random input idle bursts and result-side back-pressure.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TRIG_BITS     = 10;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned STALL_LIMIT   = 2000;  // cycles with no transfer at all
    localparam int unsigned PHASES        = 8;
    localparam int unsigned RANDOM_ITEMS  = 880;
    localparam longint unsigned Q30_ONE   = 64'd1 << 30;

    typedef enum logic {ROW_ITEM, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        ttcb_pkg::t_ttcb_in     item;
        ttcb_pkg::t_cfg_idx     reg_idx;
        logic  [16:0]           reg_val;
        logic                   typed;       // expected result written into the row
        ttcb_pkg::t_ttcb_out    typed_res;
    } t_stim_row;

    logic                            i_clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    ttcb_pkg::t_ttcb_in              in_data = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    ttcb_pkg::t_ttcb_out             out_data;
    logic                            cfg_we = 1'b0;
    logic [ttcb_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [ttcb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // scan predictor state
    logic        [16:0] thr_ms;
    logic        [15:0] first_angle;
    logic        [11:0] step_angle;
    logic        [15:0] scan_angle;
    longint             scan_min_ttc;
    logic signed [15:0] held_vx;
    logic signed [15:0] held_vy;

    ttcb_pkg::t_ttcb_out pending_scans[$];
    t_stim_row           directed_rows[$];

    int          faults = 0;
    int          transfers = 0;
    int          scans_checked = 0;
    int          settings_used = 0;
    int unsigned quiet_cycles = 0;
    int unsigned stall_run = 0;
    logic        calm_tail = 1'b0;

    always #1 i_clk = ~i_clk;

    lidar_time_to_collision_brake_core #(
        .TRIG_TABLE_BITS (TRIG_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // sin over a quarter turn, r in 0..16384, odd series to degree 11 in Q30
    function automatic longint unsigned quarter_wave(input longint unsigned r);
        longint unsigned x, x2, t, s, n;
        x  = r * 64'd102944;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (n = 10; n >= 2; n -= 2)
            t = Q30_ONE - (((x2 * t) >> 30) / (n * (n + 1)));
        s = (x * t) >> 30;
        s = (s + 64'd16384) >> 15;
        if (s > 64'd32767)
            s = 64'd32767;
        return s;
    endfunction

    // table sine of a binary angle, Q1.15, index truncated to TRIG_BITS
    function automatic int sine_q15(input logic [15:0] a);
        logic [15:0]     p;
        longint unsigned r;
        int              v;
        p = (a >> (16 - TRIG_BITS)) << (16 - TRIG_BITS);
        r = p[13:0];
        if (p[14])
            r = 64'd16384 - r;
        v = int'(quarter_wave(r));
        return p[15] ? -v : v;
    endfunction

    function automatic void reset_prediction();
        thr_ms       = ttcb_pkg::THRESHOLD_RST;
        first_angle  = ttcb_pkg::START_ANGLE_RST;
        step_angle   = ttcb_pkg::ANGLE_STEP_RST;
        scan_angle   = ttcb_pkg::START_ANGLE_RST;
        scan_min_ttc = ttcb_pkg::TTC_CEIL_MS;
        held_vx      = '0;
        held_vy      = '0;
    endfunction

    // advances the scan by one transfer; returns 1 when a scan result is due
    function automatic bit advance_scan(input ttcb_pkg::t_ttcb_in it,
                                        output ttcb_pkg::t_ttcb_out res);
        longint c_val, s_val, rate, num, ttc;
        res = '0;
        if (it.req_type == ttcb_pkg::REQ_VELOCITY) begin
            held_vx = it.vel_x_mm_s;
            held_vy = it.vel_y_mm_s;
            return 1'b0;
        end
        if (it.range_valid) begin
            c_val = sine_q15(scan_angle + ttcb_pkg::QUARTER_TURN);
            s_val = sine_q15(scan_angle);
            rate  = c_val * longint'(held_vx) + s_val * longint'(held_vy);
            if (rate > 0) begin
                num = longint'(it.range_mm) * 1000 * 32768;
                ttc = num / rate;
                if (ttc < scan_min_ttc)
                    scan_min_ttc = ttc;
            end
        end
        scan_angle = scan_angle + {4'd0, step_angle};
        if (!it.last_beam)
            return 1'b0;
        res.brake      = (scan_min_ttc <= longint'(thr_ms));
        res.min_ttc_ms = scan_min_ttc[16:0];
        scan_min_ttc   = ttcb_pkg::TTC_CEIL_MS;
        scan_angle     = first_angle;
        return 1'b1;
    endfunction

    function automatic t_stim_row beam_row(input logic [15:0] r, input logic v,
                                           input logic l, input logic typed,
                                           input logic brk, input logic [16:0] mn);
        t_stim_row row;
        row.kind                 = ROW_ITEM;
        row.item                 = '0;
        row.item.req_type        = ttcb_pkg::REQ_RANGE;
        row.item.range_mm        = r;
        row.item.range_valid     = v;
        row.item.last_beam       = l;
        row.item.vel_x_mm_s      = 16'($urandom);
        row.item.vel_y_mm_s      = 16'($urandom);
        row.reg_idx              = ttcb_pkg::CFG_TTC_THRESHOLD;
        row.reg_val              = '0;
        row.typed                = typed;
        row.typed_res.brake      = brk;
        row.typed_res.min_ttc_ms = mn;
        return row;
    endfunction

    function automatic t_stim_row vel_row(input logic [15:0] vx, input logic [15:0] vy,
                                          input logic l);
        t_stim_row row;
        row                  = beam_row(16'($urandom), 1'($urandom), l, 1'b0, 1'b0, '0);
        row.item.req_type    = ttcb_pkg::REQ_VELOCITY;
        row.item.vel_x_mm_s  = vx;
        row.item.vel_y_mm_s  = vy;
        return row;
    endfunction

    function automatic t_stim_row write_row(input ttcb_pkg::t_cfg_idx idx,
                                            input logic [16:0] val);
        t_stim_row row;
        row         = beam_row('0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        row.kind    = ROW_WRITE;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic logic [15:0] pick_velocity();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            1: return $urandom_range(0, 1) ? 16'($urandom_range(0, 200))
                                           : -16'($urandom_range(0, 200));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic ttcb_pkg::t_ttcb_in make_velocity_update(input logic l);
        ttcb_pkg::t_ttcb_in it;
        it             = '0;
        it.req_type    = ttcb_pkg::REQ_VELOCITY;
        it.range_valid = 1'($urandom);
        it.last_beam   = l;
        it.range_mm    = 16'($urandom);
        it.vel_x_mm_s  = pick_velocity();
        it.vel_y_mm_s  = pick_velocity();
        return it;
    endfunction

    function automatic ttcb_pkg::t_ttcb_in make_range_sample(input logic l);
        ttcb_pkg::t_ttcb_in it;
        it             = '0;
        it.req_type    = ttcb_pkg::REQ_RANGE;
        it.range_valid = ($urandom_range(0, 6) != 0);
        it.last_beam   = l;
        it.vel_x_mm_s  = 16'($urandom);
        it.vel_y_mm_s  = 16'($urandom);
        case ($urandom_range(0, 9))
            0:       it.range_mm = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            1, 2, 3: it.range_mm = 16'($urandom);
            default: it.range_mm = 16'($urandom_range(0, 4000));
        endcase
        return it;
    endfunction

    task automatic idle_cycles(input int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic send_item(input ttcb_pkg::t_ttcb_in it, input logic typed,
                             input ttcb_pkg::t_ttcb_out typed_res);
        ttcb_pkg::t_ttcb_out res;
        bit                  due;
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge i_clk);
        while (in_stall !== 1'b0)
            @(posedge i_clk);
        due = advance_scan(it, res);
        if (due)
            pending_scans.push_back(typed ? typed_res : res);
        transfers++;
    endtask

    task automatic send_random(input ttcb_pkg::t_ttcb_in it, input bit gappy);
        if (gappy && $urandom_range(0, 2) == 0)
            idle_cycles($urandom_range(1, 17));
        send_item(it, 1'b0, '0);
    endtask

    // hold the input off until every scan result is back and the engine is quiet
    task automatic wait_for_results();
        idle_cycles(1);
        while (pending_scans.size() != 0)
            @(negedge i_clk);
        idle_cycles(SETTLE_CYCLES);
    endtask

    task automatic write_reg(input ttcb_pkg::t_cfg_idx idx, input logic [16:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        case (idx)
            ttcb_pkg::CFG_TTC_THRESHOLD: thr_ms = val;
            ttcb_pkg::CFG_START_ANGLE: begin
                first_angle = val[15:0];
                scan_angle  = val[15:0];
            end
            ttcb_pkg::CFG_ANGLE_STEP:    step_angle = val[11:0];
            default: ;
        endcase
    endtask

    // result-side back-pressure in bursts
    always @(negedge i_clk) begin
        if (!rst_n || calm_tail) begin
            out_stall <= 1'b0;
            stall_run <= 0;
        end else if (stall_run != 0) begin
            stall_run <= stall_run - 1;
        end else if ($urandom_range(0, 2) == 0) begin
            out_stall <= 1'b1;
            stall_run <= $urandom_range(0, 16);
        end else begin
            out_stall <= 1'b0;
            stall_run <= $urandom_range(0, 30);
        end
    end

    always @(posedge i_clk) begin : result_check
        ttcb_pkg::t_ttcb_out want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
            scans_checked++;
            if (pending_scans.size() == 0) begin
                $error("scan result with nothing expected: brake %0b min_ttc_ms %0d",
                       out_data.brake, out_data.min_ttc_ms);
                faults++;
            end else begin
                want = pending_scans.pop_front();
                if (out_data.brake !== want.brake) begin
                    $error("brake: expected %0b, got %0b", want.brake, out_data.brake);
                    faults++;
                end
                if (out_data.min_ttc_ms !== want.min_ttc_ms) begin
                    $error("min_ttc_ms: expected %0d, got %0d",
                           want.min_ttc_ms, out_data.min_ttc_ms);
                    faults++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        ttcb_pkg::t_ttcb_in it;
        t_stim_row          row;
        logic [16:0]        thr_val;
        logic [15:0]        start_val;
        logic [11:0]        step_val;
        int                 phase_target;
        int                 beams;
        bit                 gappy;

        reset_prediction();

        // reset state: zero velocity gives no closing rate
        directed_rows.push_back(beam_row(16'd1000, 1'b1, 1'b1, 1'b1, 1'b0,
                                         ttcb_pkg::TTC_CEIL_MS));
        directed_rows.push_back(beam_row(16'd0, 1'b0, 1'b1, 1'b1, 1'b0,
                                         ttcb_pkg::TTC_CEIL_MS));
        directed_rows.push_back(write_row(ttcb_pkg::CFG_START_ANGLE, 17'd0));
        directed_rows.push_back(write_row(ttcb_pkg::CFG_ANGLE_STEP, 17'd0));
        // last_beam on a velocity update is ignored
        directed_rows.push_back(vel_row(16'h7FFF, 16'h0000, 1'b1));
        directed_rows.push_back(beam_row(16'd0, 1'b1, 1'b1, 1'b1, 1'b1, 17'd0));
        directed_rows.push_back(beam_row(16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0, '0));
        directed_rows.push_back(beam_row(16'd100, 1'b0, 1'b0, 1'b0, 1'b0, '0));
        directed_rows.push_back(beam_row(16'd40000, 1'b1, 1'b1, 1'b0, 1'b0, '0));
        // receding: negative closing rate
        directed_rows.push_back(vel_row(16'h8000, 16'h8000, 1'b0));
        directed_rows.push_back(beam_row(16'd5000, 1'b1, 1'b1, 1'b1, 1'b0,
                                         ttcb_pkg::TTC_CEIL_MS));
        directed_rows.push_back(write_row(ttcb_pkg::CFG_TTC_THRESHOLD, 17'd0));
        directed_rows.push_back(vel_row(16'd1, 16'd0, 1'b0));
        directed_rows.push_back(beam_row(16'd0, 1'b1, 1'b1, 1'b1, 1'b1, 17'd0));
        directed_rows.push_back(beam_row(16'd1, 1'b1, 1'b1, 1'b0, 1'b0, '0));
        // threshold above the ceiling always brakes
        directed_rows.push_back(write_row(ttcb_pkg::CFG_TTC_THRESHOLD, 17'h1FFFF));
        directed_rows.push_back(beam_row(16'd0, 1'b0, 1'b1, 1'b1, 1'b1,
                                         ttcb_pkg::TTC_CEIL_MS));
        // angle wraps, velocity changes mid-scan
        directed_rows.push_back(write_row(ttcb_pkg::CFG_START_ANGLE, 17'h07FFF));
        directed_rows.push_back(write_row(ttcb_pkg::CFG_ANGLE_STEP, 17'hFFF));
        directed_rows.push_back(vel_row(16'h8000, 16'h7FFF, 1'b0));
        directed_rows.push_back(beam_row(16'd30000, 1'b1, 1'b0, 1'b0, 1'b0, '0));
        directed_rows.push_back(beam_row(16'd1234, 1'b1, 1'b0, 1'b0, 1'b0, '0));
        directed_rows.push_back(beam_row(16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0, '0));
        directed_rows.push_back(beam_row(16'd500, 1'b0, 1'b0, 1'b0, 1'b0, '0));
        directed_rows.push_back(vel_row(16'd20000, -16'sd20000, 1'b1));
        directed_rows.push_back(beam_row(16'd800, 1'b1, 1'b0, 1'b0, 1'b0, '0));
        directed_rows.push_back(beam_row(16'd2500, 1'b1, 1'b1, 1'b0, 1'b0, '0));
        // threshold equal to the ceiling
        directed_rows.push_back(write_row(ttcb_pkg::CFG_TTC_THRESHOLD,
                                          ttcb_pkg::TTC_CEIL_MS));
        directed_rows.push_back(write_row(ttcb_pkg::CFG_START_ANGLE, 17'h08000));
        directed_rows.push_back(write_row(ttcb_pkg::CFG_ANGLE_STEP, 17'd2048));
        directed_rows.push_back(beam_row(16'd0, 1'b0, 1'b1, 1'b1, 1'b1,
                                         ttcb_pkg::TTC_CEIL_MS));

        repeat (12) @(negedge i_clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE) begin
                wait_for_results();
                write_reg(row.reg_idx, row.reg_val);
                settings_used++;
            end else begin
                send_item(row.item, row.typed, row.typed_res);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_for_results();
            calm_tail = (phase == PHASES - 1);
            case (phase)
                0: begin
                    thr_val = '0; start_val = 16'h8000; step_val = '0;
                end
                1: begin
                    thr_val = ttcb_pkg::TTC_CEIL_MS; start_val = 16'h7FFF; step_val = 12'hFFF;
                end
                default: begin
                    thr_val   = ($urandom_range(0, 3) == 0) ? 17'($urandom_range(0, 131071))
                                                            : 17'($urandom_range(0, 3000));
                    start_val = 16'($urandom);
                    step_val  = 12'($urandom_range(0, 4095));
                end
            endcase
            write_reg(ttcb_pkg::CFG_TTC_THRESHOLD, thr_val);
            write_reg(ttcb_pkg::CFG_START_ANGLE, {1'b0, start_val});
            write_reg(ttcb_pkg::CFG_ANGLE_STEP, {5'd0, step_val});
            settings_used++;

            phase_target = transfers + RANDOM_ITEMS / PHASES;
            while (transfers < phase_target) begin
                gappy = !calm_tail && $urandom_range(0, 1);
                beams = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 12);
                if ($urandom_range(0, 2) != 0)
                    send_random(make_velocity_update($urandom_range(0, 1)), gappy);
                for (int b = 0; b < beams; b++) begin
                    if ($urandom_range(0, 11) == 0)
                        send_random(make_velocity_update($urandom_range(0, 1)), gappy);
                    // a stray last_beam now and then cuts a scan short
                    it = make_range_sample((b == beams - 1) || ($urandom_range(0, 29) == 0));
                    send_random(it, gappy);
                end
                if ($urandom_range(0, 11) == 0)
                    wait_for_results();
            end
        end

        wait_for_results();
        $display("Checked %0d scan results from %0d input transfers over %0d register settings",
                 scans_checked, transfers, settings_used);
        $display("Directed corners, then random scans with skipped beams and back-pressure");
        if (faults == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
src/ttcb_pkg.sv
src/ttcb_trig_rom.sv
src/ttcb_engine.sv
src/lidar_time_to_collision_brake_core.sv
tb/sv/testbench.sv
